// File: src/bitset_word_set_operation_engine_macros.svh
// Assertion macros shared by the bitset word set-operation engine RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef BITSET_WORD_SET_OPERATION_ENGINE_MACROS_SVH
`define BITSET_WORD_SET_OPERATION_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked at every rising clock edge outside of reset.
`define BSWE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bswe assertion failed");
// Condition that must never hold outside of reset.
`define BSWE_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("bswe forbidden condition seen");
`else
`define BSWE_ASSERT(lbl, clk, rstn, prop)
`define BSWE_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: src/bswe_pkg.sv
// Package for the bitset word set-operation engine: widths, operation codes,
// the front-to-back item type and the bit-scan helper functions. No dependencies.
package bswe_pkg;

  localparam int WORD_W      = 64;
  localparam int BIT_W       = 6;   // bit index inside one word
  localparam int POP_W       = 7;   // population count of one word, 0..64
  localparam int IDX_W       = 6;   // word index, wraps past 63
  localparam int POS_W       = 12;  // bit position over the whole bitset
  localparam int CNT_W       = 13;  // running population count
  localparam int OP_W        = 3;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 104;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Operation codes carried in the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_COPY  = 3'd0,
    OP_UNION = 3'd1,
    OP_AND   = 3'd2,
    OP_DIFF  = 3'd3,
    OP_XOR   = 3'd4
  } op_e;

  // One classified word pair handed from the front to the back.
  typedef struct packed {
    logic [WORD_W-1:0] result_word;
    logic [POP_W-1:0]  pop_cnt;
    logic              nonzero;
    logic [BIT_W-1:0]  low_bit;
    logic [BIT_W-1:0]  high_bit;
    logic              common;
    logic              last;
  } item_t;

  // Number of set bits in a word.
  function automatic logic [POP_W-1:0] popcount(input logic [WORD_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + POP_W'(v[i]);
    end
    return n;
  endfunction

  // Index of the lowest set bit; zero for an empty word.
  function automatic logic [BIT_W-1:0] low_one(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] n;
    n = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = BIT_W'(i);
      end
    end
    return n;
  endfunction

  // Index of the highest set bit; zero for an empty word.
  function automatic logic [BIT_W-1:0] high_one(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) begin
        n = BIT_W'(i);
      end
    end
    return n;
  endfunction

endpackage

// File: src/bswe_front.sv
// Front stage of the bitset word set-operation engine: combines a word pair
// and classifies the result word. Depends on bswe_pkg.
module bswe_front (
  input  logic [bswe_pkg::OP_W-1:0]   req_type_i,
  input  logic [bswe_pkg::WORD_W-1:0] word_a_i,
  input  logic [bswe_pkg::WORD_W-1:0] word_b_i,
  input  logic                        last_word_i,
  output bswe_pkg::item_t             item_o
);

  logic [bswe_pkg::WORD_W-1:0] result_word;

  // Apply the requested operation; unused codes give an empty word.
  always_comb begin
    unique case (req_type_i)
      bswe_pkg::OP_COPY:  result_word = word_a_i;
      bswe_pkg::OP_UNION: result_word = word_a_i | word_b_i;
      bswe_pkg::OP_AND:   result_word = word_a_i & word_b_i;
      bswe_pkg::OP_DIFF:  result_word = word_a_i & ~word_b_i;
      bswe_pkg::OP_XOR:   result_word = word_a_i ^ word_b_i;
      default:            result_word = '0;
    endcase
  end

  // Count and scan the result word for the back stage.
  always_comb begin
    item_o.result_word = result_word;
    item_o.pop_cnt     = bswe_pkg::popcount(result_word);
    item_o.nonzero     = |result_word;
    item_o.low_bit     = bswe_pkg::low_one(result_word);
    item_o.high_bit    = bswe_pkg::high_one(result_word);
    item_o.common      = |(word_a_i & word_b_i);
    item_o.last        = last_word_i;
  end

endmodule

// File: src/bswe_fifo.sv
// Short register queue that decouples the front and back stages.
// Depends on bswe_pkg and the assertion macro header.
`include "bitset_word_set_operation_engine_macros.svh"

module bswe_fifo #(
  parameter int DEPTH = bswe_pkg::FIFO_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  bswe_pkg::item_t wr_item_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output bswe_pkg::item_t rd_item_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bswe_pkg::item_t mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            push, pop;

  assign wr_ready_o = (count_q != CW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  // The fill level never passes the depth and tracks pushes and pops.
  `BSWE_NEVER(a_fifo_overfill, clk_i, rst_ni, count_q > CW'(DEPTH))
  `BSWE_ASSERT(a_fifo_push_only, clk_i, rst_ni, push && !pop |=> count_q == $past(count_q) + 1'b1)
  `BSWE_ASSERT(a_fifo_pop_only, clk_i, rst_ni, pop && !push |=> count_q == $past(count_q) - 1'b1)

endmodule

// File: src/bswe_back.sv
// Back stage of the bitset word set-operation engine: accumulates the run
// totals and holds the result in an output register. Depends on bswe_pkg.
`include "bitset_word_set_operation_engine_macros.svh"

module bswe_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  bswe_pkg::item_t                  in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bswe_pkg::OUT_TDATA_W-1:0] out_data_o,
  output logic                             out_last_o
);

  localparam int PAD_W = bswe_pkg::OUT_TDATA_W - bswe_pkg::WORD_W - bswe_pkg::CNT_W
                         - 2 * bswe_pkg::POS_W - 1;

  // Run state.
  logic [bswe_pkg::IDX_W-1:0] word_index_q, word_index_d;
  logic [bswe_pkg::CNT_W-1:0] count_q, count_d;
  logic                       low_found_q, low_found_d;
  logic [bswe_pkg::POS_W-1:0] low_pos_q, low_pos_d;
  logic [bswe_pkg::POS_W-1:0] high_pos_q, high_pos_d;
  logic                       common_q, common_d;

  // Output register.
  logic                          out_valid_q;
  logic [bswe_pkg::WORD_W-1:0]   out_word_q;
  logic [bswe_pkg::CNT_W-1:0]    out_count_q;
  logic [bswe_pkg::POS_W-1:0]    out_low_q;
  logic [bswe_pkg::POS_W-1:0]    out_high_q;
  logic                          out_common_q;
  logic                          out_last_q;

  logic                       pop;
  logic [bswe_pkg::CNT_W:0]   cnt_sum;
  logic [bswe_pkg::CNT_W-1:0] cnt_sat;
  logic [bswe_pkg::POS_W-1:0] base;
  logic [bswe_pkg::POS_W-1:0] low_new, high_new;
  logic                       low_found_new, common_new;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign pop        = in_valid_i && in_ready_o;

  // Totals including the word being taken.
  always_comb begin
    base          = {word_index_q, {bswe_pkg::BIT_W{1'b0}}};
    cnt_sum       = {1'b0, count_q} + (bswe_pkg::CNT_W + 1)'(in_item_i.pop_cnt);
    cnt_sat       = cnt_sum[bswe_pkg::CNT_W] ? bswe_pkg::CNT_MAX
                                             : cnt_sum[bswe_pkg::CNT_W-1:0];
    low_found_new = low_found_q;
    low_new       = low_pos_q;
    high_new      = high_pos_q;
    if (in_item_i.nonzero) begin
      if (!low_found_q) begin
        low_found_new = 1'b1;
        low_new       = base | bswe_pkg::POS_W'(in_item_i.low_bit);
      end
      high_new = base | bswe_pkg::POS_W'(in_item_i.high_bit);
    end
    common_new = common_q || in_item_i.common;
  end

  // Next run state: the last word clears everything.
  always_comb begin
    word_index_d = word_index_q;
    count_d      = count_q;
    low_found_d  = low_found_q;
    low_pos_d    = low_pos_q;
    high_pos_d   = high_pos_q;
    common_d     = common_q;
    if (pop) begin
      if (in_item_i.last) begin
        word_index_d = '0;
        count_d      = '0;
        low_found_d  = 1'b0;
        low_pos_d    = '0;
        high_pos_d   = '0;
        common_d     = 1'b0;
      end else begin
        word_index_d = word_index_q + 1'b1;
        count_d      = cnt_sat;
        low_found_d  = low_found_new;
        low_pos_d    = low_new;
        high_pos_d   = high_new;
        common_d     = common_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_index_q <= '0;
      count_q      <= '0;
      low_found_q  <= 1'b0;
      low_pos_q    <= '0;
      high_pos_q   <= '0;
      common_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      word_index_q <= word_index_d;
      count_q      <= count_d;
      low_found_q  <= low_found_d;
      low_pos_q    <= low_pos_d;
      high_pos_q   <= high_pos_d;
      common_q     <= common_d;
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload is loaded whenever a word is taken.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_word_q   <= in_item_i.result_word;
      out_count_q  <= cnt_sat;
      out_low_q    <= low_new;
      out_high_q   <= high_new;
      out_common_q <= common_new;
      out_last_q   <= in_item_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {{PAD_W{1'b0}}, out_common_q, out_high_q, out_low_q,
                        out_count_q, out_word_q};

  // A closing word restarts the run; other words advance the index.
  `BSWE_ASSERT(a_back_close, clk_i, rst_ni, pop && in_item_i.last |=> word_index_q == '0 && count_q == '0)
  `BSWE_ASSERT(a_back_step, clk_i, rst_ni, pop && !in_item_i.last |=> word_index_q == $past(word_index_q) + 1'b1)
  // Positions stay zero until a result bit has been seen.
  `BSWE_ASSERT(a_back_empty_pos, clk_i, rst_ni, !low_found_q |-> low_pos_q == '0 && high_pos_q == '0)

endmodule

// File: src/bitset_word_set_operation_engine.sv
// A word pair enters the queue at its accepting edge and loads the output register when the
// back stage takes it from the queue, which waits while a held result is not yet taken.
// Throughput: one word pair per cycle while the result stream is not held back, set by the popcount
// and bit scan in the front stage and the accumulate in the back stage, with a two-entry queue between them.
// Reset (rst_ni low, asynchronous) clears the queue, the output valid flag and the run totals.
// Top level; depends on bswe_pkg, bswe_front, bswe_fifo and bswe_back.
module bitset_word_set_operation_engine #(
  parameter int FIFO_DEPTH = bswe_pkg::FIFO_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [63:0] word_a, [127:64] word_b
  input  logic [bswe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] req_type
  input  logic [bswe_pkg::OP_W-1:0]        s_axis_tuser,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [63:0] result_word, [76:64] bit_count, [88:77] lowest_position,
  // [100:89] highest_position, [101] sets_intersect, [103:102] zero
  output logic [bswe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast
);

  bswe_pkg::item_t front_item;
  bswe_pkg::item_t back_item;
  logic            back_valid, back_ready;

  // Combine and classify each incoming word pair.
  bswe_front u_front (
    .req_type_i  (s_axis_tuser),
    .word_a_i    (s_axis_tdata[bswe_pkg::WORD_W-1:0]),
    .word_b_i    (s_axis_tdata[2*bswe_pkg::WORD_W-1:bswe_pkg::WORD_W]),
    .last_word_i (s_axis_tlast),
    .item_o      (front_item)
  );

  // Queue between the classifier and the accumulator.
  bswe_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s_axis_tvalid),
    .wr_ready_o (s_axis_tready),
    .wr_item_i  (front_item),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready),
    .rd_item_o  (back_item)
  );

  // Accumulate run totals and drive the result stream.
  bswe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (back_valid),
    .in_ready_o  (back_ready),
    .in_item_i   (back_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// File: verif/tb.sv
// Testbench for bitset_word_set_operation_engine: streams random and directed word pairs
// and checks every result word and running total against an in-bench predictor.
// Depends on bswe_pkg and the engine RTL.

// Expected result of one word pair, in output field order.
typedef struct packed {
  logic [63:0] word;
  logic [12:0] count;
  logic [11:0] low_pos;
  logic [11:0] high_pos;
  logic        overlap;
  logic        done;
} set_result_t;

// Tracks the run totals of the result set and holds the results still to come.
class set_op_scoreboard;
  logic [5:0]  word_idx;
  logic [12:0] pop_total;
  logic        low_seen;
  logic [11:0] low_pos;
  logic [11:0] high_pos;
  logic        overlap_seen;
  set_result_t awaited[$];
  int unsigned errors;

  function new();
    clear_run();
    errors = 0;
  endfunction

  function void clear_run();
    word_idx     = '0;
    pop_total    = '0;
    low_seen     = 1'b0;
    low_pos      = '0;
    high_pos     = '0;
    overlap_seen = 1'b0;
  endfunction

  // Fold one accepted word pair into the run and queue the result it must give.
  function void note_word(logic [2:0] op, logic [63:0] a, logic [63:0] b, logic last);
    logic [63:0] r;
    logic [11:0] base;
    int          sum;
    int          lo;
    int          hi;
    set_result_t res;
    case (op)
      bswe_pkg::OP_COPY:  r = a;
      bswe_pkg::OP_UNION: r = a | b;
      bswe_pkg::OP_AND:   r = a & b;
      bswe_pkg::OP_DIFF:  r = a & ~b;
      bswe_pkg::OP_XOR:   r = a ^ b;
      default:            r = '0;
    endcase
    // Running count saturates at the top of its 13 bits.
    sum = int'(pop_total) + $countones(r);
    pop_total = (sum > 8191) ? 13'h1FFF : 13'(sum);
    base = {word_idx, 6'b0};
    if (r != '0) begin
      lo = 0;
      while (!r[lo]) lo++;
      hi = 63;
      while (!r[hi]) hi--;
      if (!low_seen) begin
        low_seen = 1'b1;
        low_pos  = base + 12'(lo);
      end
      high_pos = base + 12'(hi);
    end
    if ((a & b) != '0) overlap_seen = 1'b1;
    res.word     = r;
    res.count    = pop_total;
    res.low_pos  = low_pos;
    res.high_pos = high_pos;
    res.overlap  = overlap_seen;
    res.done     = last;
    awaited.push_back(res);
    word_idx = word_idx + 6'd1;
    if (last) clear_run();
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  // Compare one accepted output word with the oldest expected result.
  function void check_result(logic [103:0] data, logic tlast);
    set_result_t want;
    if (awaited.size() == 0) begin
      $error("result word %0h arrived with no result expected", data[63:0]);
      errors++;
      return;
    end
    want = awaited.pop_front();
    compare_field("result_word", want.word, data[63:0]);
    compare_field("bit_count", 64'(want.count), 64'(data[76:64]));
    compare_field("lowest_position", 64'(want.low_pos), 64'(data[88:77]));
    compare_field("highest_position", 64'(want.high_pos), 64'(data[100:89]));
    compare_field("sets_intersect", 64'(want.overlap), 64'(data[101]));
    compare_field("run_done", 64'(want.done), 64'(tlast));
  endfunction

  function int unsigned outstanding();
    return awaited.size();
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORD_BUDGET = 1350;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [63:0] ALL_ONES = '1;

  // Operation codes the block leaves unused; they give an empty result word.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID   = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;

  set_op_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_request = 1'b0;
  bit          hold_taken = 1'b0;

  bitset_word_set_operation_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output side: check each accepted word, then choose the next ready value.
  // A single long hold-off is counted here so the input side backs up.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tlast);
    end
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one word pair, after a random idle stretch, and wait for it to be taken.
  task automatic send_word(input logic [2:0] op, input logic [63:0] a,
                           input logic [63:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(op, a, b, last);
    words_sent++;
  endtask

  // Mix of empty, full, single-bit, sparse, contiguous-run and fully random words.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return 64'd1 << $urandom_range(63);
      3:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      4:       return ALL_ONES << $urandom_range(63);
      5:       return ALL_ONES >> $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly the five real operations, now and then an unused code.
  function automatic logic [2:0] rand_op();
    if ($urandom_range(99) < 8) return 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    return 3'($urandom_range(bswe_pkg::OP_XOR, bswe_pkg::OP_COPY));
  endfunction

  initial begin
    int unsigned run_no;
    int unsigned run_len;
    int unsigned phase;
    bit          mixed;
    bit          dense;
    logic [2:0]  op;
    logic [63:0] a;
    logic [63:0] b;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: each operation alone, extreme words, unused codes, two mixed runs.
    send_word(bswe_pkg::OP_COPY, '0, ALL_ONES, 1'b1);
    send_word(bswe_pkg::OP_UNION, ALL_ONES, ALL_ONES, 1'b1);
    send_word(bswe_pkg::OP_AND, 64'd1 << 63, (64'd1 << 63) | 64'd1, 1'b1);
    send_word(bswe_pkg::OP_DIFF, ALL_ONES, {16{4'h5}}, 1'b1);
    send_word(bswe_pkg::OP_XOR, {16{4'hA}}, {16{4'h5}}, 1'b1);
    send_word(OP_SPARE_FIRST, ALL_ONES, ALL_ONES, 1'b1);
    send_word(OP_SPARE_MID, ALL_ONES, 64'd1, 1'b1);
    send_word(OP_SPARE_LAST, 64'd1 << 63, 64'd1 << 63, 1'b1);
    send_word(bswe_pkg::OP_COPY, '0, '0, 1'b0);
    send_word(bswe_pkg::OP_UNION, 64'd1 << 5, '0, 1'b0);
    send_word(bswe_pkg::OP_AND, ALL_ONES, 64'd1 << 63, 1'b0);
    send_word(OP_SPARE_FIRST, ALL_ONES, '0, 1'b0);
    send_word(bswe_pkg::OP_XOR, 64'd1, 64'd1, 1'b1);
    send_word(bswe_pkg::OP_DIFF, ALL_ONES, ALL_ONES, 1'b0);
    send_word(bswe_pkg::OP_UNION, '0, 64'd1 << 63, 1'b0);
    send_word(bswe_pkg::OP_COPY, 64'd1, '0, 1'b1);

    // Random runs across the idling phases; one long dense run saturates the count
    // and wraps the word index.
    run_no = 0;
    while (words_sent < WORD_BUDGET) begin
      phase = words_sent * 5 / WORD_BUDGET;
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
        3:       begin send_idle_pct = 23; recv_stall_pct = 23; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_request = 1'b1; end
      endcase
      dense = 1'b0;
      if (run_no == 5) begin
        run_len = 150;
        dense   = 1'b1;
      end else if ($urandom_range(99) < 2) begin
        run_len = $urandom_range(140, 65);
        dense   = $urandom_range(1);
      end else if ($urandom_range(99) < 10) begin
        run_len = $urandom_range(64, 13);
      end else begin
        run_len = $urandom_range(12, 1);
      end
      mixed = ($urandom_range(99) < 30);
      op = dense ? 3'(bswe_pkg::OP_UNION) : rand_op();
      for (int unsigned w = 0; w < run_len; w++) begin
        if (mixed && !dense) op = rand_op();
        a = (dense && $urandom_range(3) != 0) ? ALL_ONES : rand_word();
        b = rand_word();
        send_word(op, a, b, w == run_len - 1);
      end
      run_no++;
    end
    s_axis_tvalid <= 1'b0;

    // Let the last results drain, then report.
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+src
src/bswe_pkg.sv
src/bswe_front.sv
src/bswe_fifo.sv
src/bswe_back.sv
src/bitset_word_set_operation_engine.sv
verif/tb.sv
